/* hdl/tss_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and the reciprocal table for the Taylor-series sine block.
package tss_pkg;

	// Field widths of the channels
	localparam int ANGLE_W = 32;
	localparam int COUNT_W = 5;
	localparam int SINE_W  = 48;

	// Parameter defaults
	localparam int MAX_TERMS_DEF = 16;
	localparam int FRAC_BITS_DEF = 28;

	// Term magnitude, accumulator and multiplier widths
	localparam int TERM_W = 62;
	localparam int ACC_W  = 64;
	localparam int WORD_W = 32;
	localparam int OPND_W = 2 * WORD_W;
	localparam int PROD_W = 2 * OPND_W;

	// Accumulator and output limits
	localparam logic signed [ACC_W-1:0] ACC_HI = 64'sh4000_0000_0000_0000;
	localparam logic signed [ACC_W-1:0] ACC_LO = -64'sh4000_0000_0000_0000;
	localparam logic signed [ACC_W-1:0] OUT_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] OUT_LO = -64'sh0000_8000_0000_0000;

	// Reciprocals round(2^32 / ((2k)(2k+1))) in Q0.32; entry 0 is unused
	localparam int RECIP_BITS  = 32;
	localparam int RECIP_DEPTH = 32;
	localparam int RECIP_IDX_W = 5;
	localparam logic [RECIP_BITS-1:0] RECIP_LUT [RECIP_DEPTH] = '{
		32'd0,         32'd715827883, 32'd214748365, 32'd102261126,
		32'd59652324,  32'd39045157,  32'd27531842,  32'd20452225,
		32'd15790321,  32'd12558384,  32'd10226113,  32'd8488078,
		32'd7158279,   32'd6118187,   32'd5289369,   32'd4618244,
		32'd4067204,   32'd3609216,   32'd3224450,   32'd2898089,
		32'd2618882,   32'd2378166,   32'd2169175,   32'd1986571,
		32'd1826092,   32'd1684301,   32'd1558406,   32'd1446117,
		32'd1345541,   32'd1255104,   32'd1173488,   32'd1099582
	};

	// Channel payloads
	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic [COUNT_W-1:0]        term_count;
	} in_t;

	typedef struct packed {
		logic signed [SINE_W-1:0] sine_value;
		logic                     saturated;
	} out_t;

endpackage

/* hdl/tss_mul.sv */
`timescale 1ns / 1ps
// Iterative 64x64 multiplier built on one 32x32 multiplier with a 128-bit accumulator.
module tss_mul
	import tss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OPND_W-1:0] a,
	input  logic [OPND_W-1:0] b,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	logic              busy_q;
	logic              done_q;
	logic [2:0]        cnt_q;
	logic [1:0]        last_q;
	logic [OPND_W-1:0] a_q;
	logic [OPND_W-1:0] b_q;
	logic [OPND_W-1:0] pp_s1;
	logic [1:0]        wt_s1;
	logic [PROD_W-1:0] acc_q;

	logic [1:0]        mul_idx;
	logic [WORD_W-1:0] a_half;
	logic [WORD_W-1:0] b_half;
	logic [OPND_W-1:0] pp_next;
	logic [PROD_W-1:0] add_term;
	logic              mul_now;
	logic              add_now;
	logic              finish;

	// Pick the word pair for this partial product: bit 0 picks a, bit 1 picks b
	always_comb begin
		mul_idx = cnt_q[1:0];
		a_half  = mul_idx[0] ? a_q[OPND_W-1:WORD_W] : a_q[WORD_W-1:0];
		b_half  = mul_idx[1] ? b_q[OPND_W-1:WORD_W] : b_q[WORD_W-1:0];
		pp_next = OPND_W'(a_half) * OPND_W'(b_half);
		mul_now = busy_q && (cnt_q <= {1'b0, last_q});
		add_now = busy_q && (cnt_q != 3'd0);
		finish  = busy_q && (cnt_q == ({1'b0, last_q} + 3'd1));
	end

	// Align the registered partial product to its word weight
	always_comb begin
		case (wt_s1)
			2'd0:    add_term = {{OPND_W{1'b0}}, pp_s1};
			2'd1:    add_term = {{WORD_W{1'b0}}, pp_s1, {WORD_W{1'b0}}};
			2'd2:    add_term = {pp_s1, {OPND_W{1'b0}}};
			default: add_term = '0;
		endcase
	end

	// Sequence control: skip the upper partials when b fits one word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			last_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			last_q <= (b[OPND_W-1:WORD_W] == '0) ? 2'd1 : 2'd3;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (finish) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand capture, partial product register and accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else begin
			if (mul_now) begin
				pp_s1 <= pp_next;
				wt_s1 <= {1'b0, mul_idx[0]} + {1'b0, mul_idx[1]};
			end
			if (add_now) begin
				acc_q <= acc_q + add_term;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* hdl/taylor_series_sine.sv */
`timescale 1ns / 1ps
// Top level of the fixed-point Taylor-series sine: sequencer, term recurrence, accumulator.
//
// Usage: the input channel (in_valid / in_ready / in_data) takes an angle in signed
// fixed point with FRAC_BITS fraction bits and a term count; counts above MAX_TERMS
// are clamped. The output channel (out_valid / out_ready / out_data) returns one
// saturated partial sum per item, with a flag when any term, the running sum or the
// final value was clipped.
// One item is worked at a time. All products go through one shared 32x32 multiplier
// that forms 64x64 products from two or four partial products. The angle is squared
// first and the first term added; each further term is multiplied by x^2, then by
// the reciprocal, before it is added. A zero count skips the multiplier and goes
// straight to the finish state.
// in_ready is high only while the sequencer is idle. A finished result sits in the
// output register; when the receiver stalls, the next item is still taken and worked,
// and its result waits until the previous transfer completes.
// Reset: asynchronous, active low; the block comes up idle with no result pending.
module taylor_series_sine
	import tss_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int X2_W = 2 * ANGLE_W - 1 - FRAC_BITS;
	localparam int K_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int N_W  = $clog2(MAX_TERMS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SQ    = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_MX    = 3'd3;
	localparam logic [2:0] ST_MR_GO = 3'd4;
	localparam logic [2:0] ST_MR    = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]              state_q;
	logic [K_W-1:0]          k_q;
	logic                    out_valid_q;
	logic [N_W-1:0]          n_q;
	logic                    neg_q;
	logic                    flag_q;
	logic [TERM_W-1:0]       t_q;
	logic [X2_W-1:0]         x2_q;
	logic signed [ACC_W-1:0] acc_q;
	out_t                    out_q;

	logic                    accept;
	logic [ANGLE_W-1:0]      mag;
	logic [COUNT_W:0]        cnt_ext;
	logic [COUNT_W:0]        cnt_lim;
	logic [N_W-1:0]          n_in;
	logic                    last_term;
	logic                    term_neg;
	logic signed [ACC_W-1:0] t_ext;
	logic signed [ACC_W-1:0] sum;
	logic signed [ACC_W-1:0] sum_clamp;
	logic                    sum_ovf;
	logic [PROD_W-1:0]       shifted;
	logic                    cap_ovf;
	logic [TERM_W-1:0]       cap_val;
	logic signed [ACC_W-1:0] fin_clip;
	logic                    fin_ovf;
	logic                    out_free;

	logic                    mul_start;
	logic [OPND_W-1:0]       mul_a;
	logic [OPND_W-1:0]       mul_b;
	logic                    mul_done;
	logic [PROD_W-1:0]       mul_prod;

	tss_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Decode the incoming item: magnitude of the angle, clamped term count
	always_comb begin
		accept  = in_valid && in_ready;
		mag     = in_data.angle[ANGLE_W-1] ? (ANGLE_W'(0) - in_data.angle) : in_data.angle;
		cnt_ext = (COUNT_W + 1)'(in_data.term_count);
		cnt_lim = (COUNT_W + 1)'(MAX_TERMS);
		n_in    = N_W'((cnt_ext > cnt_lim) ? cnt_lim : cnt_ext);
	end

	// Running sum: add the signed term and clamp to the accumulator range
	always_comb begin
		last_term = (N_W'(k_q) + N_W'(1)) == n_q;
		term_neg  = neg_q ^ k_q[0];
		t_ext     = ACC_W'({2'b00, t_q});
		sum       = term_neg ? (acc_q - t_ext) : (acc_q + t_ext);
		sum_ovf   = 1'b0;
		sum_clamp = sum;
		if (sum > ACC_HI) begin
			sum_clamp = ACC_HI;
			sum_ovf   = 1'b1;
		end else if (sum < ACC_LO) begin
			sum_clamp = ACC_LO;
			sum_ovf   = 1'b1;
		end
	end

	// Scale the product back and cap the term magnitude
	always_comb begin
		shifted = (state_q == ST_MX) ? (mul_prod >> FRAC_BITS) : (mul_prod >> RECIP_BITS);
		cap_ovf = |shifted[PROD_W-1:TERM_W];
		cap_val = cap_ovf ? {TERM_W{1'b1}} : shifted[TERM_W-1:0];
	end

	// Clip the final sum to the output range
	always_comb begin
		fin_ovf  = 1'b0;
		fin_clip = acc_q;
		if (acc_q > OUT_HI) begin
			fin_clip = OUT_HI;
			fin_ovf  = 1'b1;
		end else if (acc_q < OUT_LO) begin
			fin_clip = OUT_LO;
			fin_ovf  = 1'b1;
		end
		out_free = !out_valid_q || out_ready;
	end

	// Drive the shared multiplier from the sequencer state
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				mul_start = accept && (n_in != '0);
				mul_a     = OPND_W'(mag);
				mul_b     = OPND_W'(mag);
			end
			ST_ADD: begin
				mul_start = !last_term;
				mul_a     = OPND_W'(t_q);
				mul_b     = OPND_W'(x2_q);
			end
			ST_MR_GO: begin
				mul_start = 1'b1;
				mul_a     = OPND_W'(t_q);
				mul_b     = OPND_W'(RECIP_LUT[RECIP_IDX_W'(k_q)]);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// Sequencer, term index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished result, or drop valid once it has been taken
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						state_q <= (n_in == '0) ? ST_FIN : ST_SQ;
					end
				end
				ST_SQ: begin
					if (mul_done) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (last_term) begin
						state_q <= ST_FIN;
					end else begin
						k_q     <= k_q + K_W'(1);
						state_q <= ST_MX;
					end
				end
				ST_MX: begin
					if (mul_done) begin
						state_q <= ST_MR_GO;
					end
				end
				ST_MR_GO: begin
					state_q <= ST_MR;
				end
				ST_MR: begin
					if (mul_done) begin
						state_q <= ST_ADD;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: operands, term, accumulator, flag, result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					neg_q  <= in_data.angle[ANGLE_W-1];
					n_q    <= n_in;
					t_q    <= TERM_W'(mag);
					acc_q  <= '0;
					flag_q <= 1'b0;
				end
			end
			ST_SQ: begin
				if (mul_done) begin
					x2_q <= mul_prod[FRAC_BITS +: X2_W];
				end
			end
			ST_ADD: begin
				acc_q  <= sum_clamp;
				flag_q <= flag_q | sum_ovf;
			end
			ST_MX, ST_MR: begin
				if (mul_done) begin
					t_q    <= cap_val;
					flag_q <= flag_q | cap_ovf;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_q.sine_value <= fin_clip[SINE_W-1:0];
					out_q.saturated  <= flag_q | fin_ovf;
				end
			end
			default: begin
				flag_q <= flag_q;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
